// ===== rtl/core/cu_pkg.sv =====
// Shared types, widths and constants for the combination unranker.
// Holds the binomial table builder and the microcode program of the sequencer.
// Depends on nothing.
`default_nettype none

package cu_pkg;

    localparam int MAX_SET_SIZE = 64;
    localparam int MAX_PICK     = 8;

    localparam int RANK_W     = 33;
    localparam int N_W        = 7;
    localparam int R_W        = 4;
    localparam int V_W        = $clog2(MAX_SET_SIZE);
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int ROM_A_W   = R_W + N_W;
    localparam int ROM_DEPTH = 2 ** ROM_A_W;
    localparam int ROM_ROW   = 2 ** N_W;

    localparam logic [N_W-1:0] SET_SIZE_RST = N_W'(52);
    localparam logic [R_W-1:0] PICK_RST     = R_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PICK     = CFG_IDX_W'(1);

    typedef logic [RANK_W-1:0] t_bin_rom [ROM_DEPTH];

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_INIT,
        ST_DUAL,
        ST_SEARCH,
        ST_DONE,
        ST_FLAG
    } t_step;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_CFG_BAD,
        CND_RANK_BAD,
        CND_NOT_LAST
    } t_cond;

    typedef enum logic {
        ASEL_CAND,
        ASEL_TOTAL
    } t_asel;

    typedef struct packed {
        logic  take_in;
        logic  load_init;
        logic  load_dual;
        logic  search;
        logic  emit_flag;
        t_asel asel;
        t_cond cond;
        t_step target;
    } t_uword;

    // Entry {k, v} holds C(v, k), built row by row with Pascal's rule.
    function automatic t_bin_rom f_build_binom();
        t_bin_rom rom;
        int       k;
        int       v;
        int       idx;
        for (k = 0; k < 2 ** R_W; k++) begin
            for (v = 0; v < ROM_ROW; v++) begin
                idx = k * ROM_ROW + v;
                if (k == 0) begin
                    rom[idx] = RANK_W'(1);
                end else if (v == 0) begin
                    rom[idx] = '0;
                end else begin
                    rom[idx] = rom[idx-1] + rom[idx-ROM_ROW-1];
                end
            end
        end
        return rom;
    endfunction

    function automatic t_uword f_ucode(t_step pc);
        t_uword uw;
        uw = '{take_in: 1'b0, load_init: 1'b0, load_dual: 1'b0, search: 1'b0,
               emit_flag: 1'b0, asel: ASEL_CAND, cond: CND_ALWAYS, target: ST_WAIT};
        case (pc)
            ST_WAIT: begin
                uw.take_in = 1'b1;
                uw.cond    = CND_NO_INPUT;
                uw.target  = ST_WAIT;
            end
            ST_INIT: begin
                uw.load_init = 1'b1;
                uw.asel      = ASEL_TOTAL;
                uw.cond      = CND_CFG_BAD;
                uw.target    = ST_FLAG;
            end
            ST_DUAL: begin
                uw.load_dual = 1'b1;
                uw.cond      = CND_RANK_BAD;
                uw.target    = ST_FLAG;
            end
            ST_SEARCH: begin
                uw.search = 1'b1;
                uw.cond   = CND_NOT_LAST;
                uw.target = ST_SEARCH;
            end
            ST_DONE: begin
                uw.target = ST_WAIT;
            end
            ST_FLAG: begin
                uw.emit_flag = 1'b1;
                uw.target    = ST_WAIT;
            end
            default: begin
                uw.target = ST_WAIT;
            end
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cu_rank_if.sv =====
// Input channel of the combination unranker: one rank per transfer.
// Depends on cu_pkg.
`default_nettype none

interface cu_rank_if;
    import cu_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] combination_rank;

    modport source (output valid, output combination_rank, input ready);
    modport sink   (input valid, input combination_rank, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cu_comb_if.sv =====
// Output channel of the combination unranker: one chosen index per transfer.
// Depends on cu_pkg.
`default_nettype none

interface cu_comb_if;
    import cu_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] element_index;
    logic             last;
    logic             out_of_range;

    modport source (output valid, output element_index, output last, output out_of_range,
                    input ready);
    modport sink   (input valid, input element_index, input last, input out_of_range,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/combination_unranker.sv =====
// Top level of the combination unranker, a microcoded sequencer over a binomial table.
// Depends on cu_pkg, cu_rank_if, cu_comb_if and cu_binom_rom.
//
// A rank m accepted on i_rank yields the m-th combination of r indices out of 0..n-1 in
// lexicographic order, sent on o_comb as r transfers in increasing order with last set on
// the final one. A rank of C(n,r) or more, or settings outside 1 <= r <= n <= 64 and
// r <= 8, yields one transfer with out_of_range and last set and index zero. The block
// takes one rank at a time. A normal rank passes through acceptance, setup and the total
// check, then tests candidate values as the candidate walks down from n-1 (at most n),
// then a finishing step before the block is ready again. The single read port of the
// binomial table sets that pace of one candidate per cycle while the result register is
// free. A flagged rank goes from setup or the total check to a flag step. A search or
// flag step waits while the result register is still full.
`default_nettype none

module combination_unranker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    cu_rank_if.sink                            i_rank,
    cu_comb_if.source                          o_comb,
    input  wire logic                          i_cfg_we,
    input  wire logic [cu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cu_pkg::*;

    t_step             r_pc, n_pc;
    logic [N_W-1:0]    r_n;
    logic [R_W-1:0]    r_r;
    logic [RANK_W-1:0] r_m, n_m;
    logic [RANK_W-1:0] r_dual, n_dual;
    logic [R_W-1:0]    r_k, n_k;
    logic [V_W-1:0]    r_v, n_v;
    logic              r_ovalid, n_ovalid;
    logic [IDX_W-1:0]  r_oidx, n_oidx;
    logic              r_olast, n_olast;
    logic              r_ooor, n_ooor;

    t_uword             uw;
    logic [ROM_A_W-1:0] rom_addr;
    logic [RANK_W-1:0]  rom_data;
    logic               out_busy;
    logic               hold;
    logic               cfg_bad;
    logic               rank_bad;
    logic               found;
    logic               cond_true;
    logic               emit;
    logic [N_W-1:0]     idx_full;

    cu_binom_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign uw       = f_ucode(r_pc);
    assign out_busy = r_ovalid && !o_comb.ready;
    assign hold     = (uw.search || uw.emit_flag) && out_busy;
    assign cfg_bad  = (r_n == '0) || (r_n > N_W'(MAX_SET_SIZE)) || (r_r == '0)
                   || (r_r > R_W'(MAX_PICK)) || (N_W'(r_r) > r_n);
    assign rank_bad = r_m >= rom_data;
    assign found    = rom_data <= r_dual;
    assign idx_full = r_n - N_W'(1) - N_W'(r_v);

    assign i_rank.ready         = uw.take_in;
    assign o_comb.valid         = r_ovalid;
    assign o_comb.element_index = r_oidx;
    assign o_comb.last          = r_olast;
    assign o_comb.out_of_range  = r_ooor;

    always_comb begin
        case (uw.cond)
            CND_ALWAYS:   cond_true = 1'b1;
            CND_NO_INPUT: cond_true = !i_rank.valid;
            CND_CFG_BAD:  cond_true = cfg_bad;
            CND_RANK_BAD: cond_true = rank_bad;
            CND_NOT_LAST: cond_true = !(found && (r_k == R_W'(1)));
            default:      cond_true = 1'b1;
        endcase

        if (hold) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = uw.target;
        end else begin
            n_pc = t_step'(r_pc + 3'd1);
        end

        n_m    = (uw.take_in && i_rank.valid) ? i_rank.combination_rank : r_m;
        n_k    = r_k;
        n_v    = r_v;
        n_dual = r_dual;
        if (uw.load_init) begin
            n_k = r_r;
            n_v = V_W'(r_n - N_W'(1));
        end
        if (uw.load_dual) begin
            n_dual = rom_data - RANK_W'(1) - r_m;
        end
        if (uw.search && !hold) begin
            n_v = r_v - V_W'(1);
            if (found) begin
                n_k    = r_k - R_W'(1);
                n_dual = r_dual - rom_data;
            end
        end

        // Outside setup, which reads the total C(n, r), the table read follows the next candidate,
        // so the data seen in a search step is C(v, k) for the current v and k.
        if (uw.asel == ASEL_TOTAL) begin
            rom_addr = {r_r, r_n};
        end else begin
            rom_addr = {n_k, N_W'(n_v)};
        end

        emit     = !hold && ((uw.search && found) || uw.emit_flag);
        n_ovalid = emit ? 1'b1 : (o_comb.ready ? 1'b0 : r_ovalid);
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        n_ooor   = r_ooor;
        if (emit) begin
            n_oidx  = uw.emit_flag ? '0 : idx_full[IDX_W-1:0];
            n_olast = uw.emit_flag ? 1'b1 : (r_k == R_W'(1));
            n_ooor  = uw.emit_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= ST_WAIT;
            r_ovalid <= 1'b0;
            r_n      <= SET_SIZE_RST;
            r_r      <= PICK_RST;
        end else begin
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_SIZE: r_n <= i_cfg_data[N_W-1:0];
                    CFG_PICK:     r_r <= i_cfg_data[R_W-1:0];
                    default:      r_n <= r_n;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_dual  <= n_dual;
        r_k     <= n_k;
        r_v     <= n_v;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
        r_ooor  <= n_ooor;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cu_binom_rom.sv =====
// Binomial coefficient table C(v, k) with a registered read port.
// Depends on cu_pkg for the table builder and widths.
`default_nettype none

module cu_binom_rom (
    input  wire logic                       i_clk,
    input  wire logic [cu_pkg::ROM_A_W-1:0] i_addr,
    output logic      [cu_pkg::RANK_W-1:0]  o_data
);
    import cu_pkg::*;

    localparam t_bin_rom BINOM_ROM = f_build_binom();

    logic [RANK_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= BINOM_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for combination_unranker: sends ranks, predicts each combination
// and checks every index transfer in order. Depends on cu_pkg, cu_rank_if, cu_comb_if and
// the combination_unranker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cu_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] element_index;
        logic             last;
        logic             out_of_range;
    } t_chosen_index;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cu_rank_if rank_ch ();
    cu_comb_if comb_ch ();

    combination_unranker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rank     (rank_ch),
        .o_comb     (comb_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [N_W-1:0] model_set_size;
    logic [R_W-1:0] model_pick_count;
    t_chosen_index  pending_picks[$];

    int send_idle_pct  = 6;
    int recv_stall_pct = 60;
    int mismatches     = 0;
    int ranks_sent     = 0;
    int picks_checked  = 0;
    int flagged_seen   = 0;
    int settings_used  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned n_choose_k(longint unsigned v, longint unsigned k);
        longint unsigned acc;
        longint unsigned i;
        acc = 1;
        if (k > v) begin
            return 0;
        end
        for (i = 0; i < k; i++) begin
            acc = (acc * (v - i)) / (i + 1);
        end
        return acc;
    endfunction

    function automatic bit settings_ok();
        return model_set_size != 0 && model_set_size <= MAX_SET_SIZE &&
               model_pick_count != 0 && model_pick_count <= MAX_PICK &&
               model_pick_count <= model_set_size;
    endfunction

    // The combination is read off the combinadic of the dual rank, largest binomial first.
    function automatic void unrank_into_picks(logic [RANK_W-1:0] rank);
        longint unsigned total;
        longint unsigned dual;
        longint unsigned b;
        int              n;
        int              r;
        int              v;
        int              k;
        t_chosen_index   pick;
        n                  = model_set_size;
        r                  = model_pick_count;
        pick.element_index = '0;
        pick.last          = 1'b1;
        pick.out_of_range  = 1'b1;
        if (!settings_ok()) begin
            pending_picks.push_back(pick);
            return;
        end
        total = n_choose_k(n, r);
        if (rank >= total) begin
            pending_picks.push_back(pick);
            return;
        end
        dual = total - 1 - rank;
        for (k = r; k >= 1; k--) begin
            v = n - 1;
            b = n_choose_k(v, k);
            while (b > dual && v > 0) begin
                v--;
                b = n_choose_k(v, k);
            end
            if (b > dual) begin
                b = 0;
            end
            dual               -= b;
            pick.element_index = IDX_W'(n - 1 - v);
            pick.last          = (k == 1);
            pick.out_of_range  = 1'b0;
            pending_picks.push_back(pick);
        end
    endfunction

    always @(posedge i_clk) begin : check_picks
        t_chosen_index got;
        t_chosen_index want;
        if (i_rst_n && comb_ch.valid && comb_ch.ready) begin
            got = {comb_ch.element_index, comb_ch.last, comb_ch.out_of_range};
            if (pending_picks.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer, expected none, actual index %0d last %0b oor %0b",
                         $time, got.element_index, got.last, got.out_of_range);
            end else begin
                want = pending_picks.pop_front();
                picks_checked++;
                if (got.out_of_range) begin
                    flagged_seen++;
                end
                if (got.element_index !== want.element_index) begin
                    mismatches++;
                    $display("%0t: element_index expected %0d actual %0d",
                             $time, want.element_index, got.element_index);
                end
                if (got.last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                end
                if (got.out_of_range !== want.out_of_range) begin
                    mismatches++;
                    $display("%0t: out_of_range expected %0b actual %0b",
                             $time, want.out_of_range, got.out_of_range);
                end
            end
        end
    end

    initial begin
        comb_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            comb_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_rank(input logic [RANK_W-1:0] rank);
        while ($urandom_range(99) < send_idle_pct) begin
            rank_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rank_ch.valid            <= 1'b1;
        rank_ch.combination_rank <= rank;
        @(posedge i_clk);
        while (!rank_ch.ready) begin
            @(posedge i_clk);
        end
        unrank_into_picks(rank);
        ranks_sent++;
    endtask

    // The block may still be finishing its last rank when the final index arrives.
    task automatic drain_and_settle();
        rank_ch.valid <= 1'b0;
        while (pending_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (MAX_SET_SIZE + 8) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] n_data,
                                  input logic [CFG_DATA_W-1:0] r_data);
        drain_and_settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SET_SIZE;
        i_cfg_data <= n_data;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PICK;
        i_cfg_data <= r_data;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        model_set_size   = n_data;
        model_pick_count = r_data[R_W-1:0];
        settings_used++;
    endtask

    task automatic test_reset_settings();
        longint unsigned total;
        total = n_choose_k(model_set_size, model_pick_count);
        send_rank(RANK_W'(0));
        send_rank(RANK_W'(total - 1));
        send_rank(RANK_W'(total));
        send_rank({RANK_W{1'b1}});
    endtask

    task automatic test_widest_settings();
        longint unsigned total;
        // The upper data bits of the pick count write must be ignored.
        apply_settings(CFG_DATA_W'(MAX_SET_SIZE), 7'h78);
        total = n_choose_k(model_set_size, model_pick_count);
        send_rank(RANK_W'(0));
        send_rank(RANK_W'(total - 1));
        send_rank(RANK_W'(total));
        send_rank(RANK_W'(total / 2));
        apply_settings(CFG_DATA_W'(MAX_SET_SIZE), CFG_DATA_W'(1));
        send_rank(RANK_W'(63));
        send_rank(RANK_W'(0));
        send_rank(RANK_W'(64));
    endtask

    task automatic test_tight_settings();
        apply_settings(CFG_DATA_W'(1), CFG_DATA_W'(1));
        send_rank(RANK_W'(0));
        send_rank(RANK_W'(1));
        apply_settings(CFG_DATA_W'(8), CFG_DATA_W'(8));
        send_rank(RANK_W'(0));
        send_rank(RANK_W'(1));
    endtask

    task automatic test_bad_settings();
        apply_settings(CFG_DATA_W'(3), CFG_DATA_W'(5));
        send_rank(RANK_W'(0));
        apply_settings(CFG_DATA_W'(0), CFG_DATA_W'(1));
        send_rank(RANK_W'(0));
        apply_settings(CFG_DATA_W'(65), CFG_DATA_W'(2));
        send_rank(RANK_W'(0));
        apply_settings({CFG_DATA_W{1'b1}}, CFG_DATA_W'(15));
        send_rank(RANK_W'(5));
        apply_settings(CFG_DATA_W'(10), CFG_DATA_W'(0));
        send_rank(RANK_W'(0));
        apply_settings(CFG_DATA_W'(10), CFG_DATA_W'(9));
        send_rank(RANK_W'(0));
    endtask

    task automatic test_random_ranks(input int count, input int send_pct, input int recv_pct);
        int              i;
        int              roll;
        int              n;
        int              r;
        longint unsigned total;
        longint unsigned rank;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (i = 0; i < count; i++) begin
            if (i % 15 == 0) begin
                roll = $urandom_range(9);
                if (roll == 0) begin
                    n = $urandom_range(127);
                    r = $urandom_range(15);
                end else begin
                    n = (roll < 5) ? $urandom_range(1, 12) : $urandom_range(1, MAX_SET_SIZE);
                    r = $urandom_range(1, (n < MAX_PICK) ? n : MAX_PICK);
                end
                apply_settings(CFG_DATA_W'(n), CFG_DATA_W'(r | ($urandom_range(7) << R_W)));
            end
            if (!settings_ok()) begin
                rank = {$urandom_range(1), $urandom};
            end else begin
                total = n_choose_k(model_set_size, model_pick_count);
                roll  = $urandom_range(19);
                if (roll == 0) begin
                    rank = 0;
                end else if (roll == 1) begin
                    rank = total - 1;
                end else if (roll == 2) begin
                    rank = total + $urandom_range(3);
                end else if (roll == 3) begin
                    rank = {$urandom_range(1), $urandom};
                end else begin
                    rank = {$urandom, $urandom} % total;
                end
            end
            send_rank(RANK_W'(rank));
        end
    endtask

    initial begin
        i_rst_n                  <= 1'b0;
        i_cfg_we                 <= 1'b0;
        i_cfg_idx                <= CFG_SET_SIZE;
        i_cfg_data               <= '0;
        rank_ch.valid            <= 1'b0;
        rank_ch.combination_rank <= '0;
        model_set_size           = SET_SIZE_RST;
        model_pick_count         = PICK_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_widest_settings();
        test_tight_settings();
        test_bad_settings();
        test_random_ranks(85, 6, 60);
        test_random_ranks(85, 60, 6);
        test_random_ranks(85, 0, 0);
        drain_and_settle();

        $display("Sent %0d ranks under %0d register settings, including invalid ones.",
                 ranks_sent, settings_used);
        $display("Checked %0d index transfers, %0d of them flagged out of range.",
                 picks_checked, flagged_seen);
        if (mismatches == 0 && pending_picks.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
